// ----- rtl/sdes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES package
// Bit tables, S-boxes and the permutation and round functions of the
// simplified DES byte cipher. Tables count from 1 at the most significant bit.
// ----------------------------------------------------------------------------
package sdes_pkg;

	localparam int KEY_W  = 10;
	localparam int DATA_W = 8;
	localparam int SUBK_W = 8;

	typedef logic [3:0] tab_idx_t;
	typedef logic [1:0] sbox_val_t;

	// Operation codes carried on the request
	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} sdes_cmd_t;

	typedef struct packed {
		logic [SUBK_W-1:0] k1;
		logic [SUBK_W-1:0] k2;
	} sdes_subkeys_t;

	localparam tab_idx_t P10_TAB   [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
	                                        4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
	localparam tab_idx_t P8_TAB    [8]  = '{4'd6, 4'd3, 4'd7, 4'd4,
	                                        4'd8, 4'd5, 4'd10, 4'd9};
	localparam tab_idx_t IP_TAB    [8]  = '{4'd2, 4'd6, 4'd3, 4'd1,
	                                        4'd4, 4'd8, 4'd5, 4'd7};
	localparam tab_idx_t EP_TAB    [8]  = '{4'd4, 4'd1, 4'd2, 4'd3,
	                                        4'd2, 4'd3, 4'd4, 4'd1};
	localparam tab_idx_t P4_TAB    [4]  = '{4'd2, 4'd4, 4'd3, 4'd1};
	localparam tab_idx_t IPINV_TAB [8]  = '{4'd4, 4'd1, 4'd3, 4'd5,
	                                        4'd7, 4'd2, 4'd8, 4'd6};

	localparam sbox_val_t S0_TAB [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
	                                        '{2'd3, 2'd2, 2'd1, 2'd0},
	                                        '{2'd0, 2'd2, 2'd1, 2'd3},
	                                        '{2'd3, 2'd1, 2'd3, 2'd2}};
	localparam sbox_val_t S1_TAB [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
	                                        '{2'd2, 2'd0, 2'd1, 2'd3},
	                                        '{2'd3, 2'd0, 2'd1, 2'd0},
	                                        '{2'd2, 2'd1, 2'd0, 2'd3}};

	// P10 on the raw key
	function automatic logic [9:0] perm_p10(input logic [9:0] v);
		logic [9:0] r;
		r = '0;
		for (int i = 0; i < 10; i++)
			r[9-i] = v[10-int'(P10_TAB[i])];
		return r;
	endfunction

	// P8 picks a subkey out of the rotated halves
	function automatic logic [7:0] perm_p8(input logic [9:0] v);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++)
			r[7-i] = v[10-int'(P8_TAB[i])];
		return r;
	endfunction

	function automatic logic [7:0] perm_ip(input logic [7:0] v);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++)
			r[7-i] = v[8-int'(IP_TAB[i])];
		return r;
	endfunction

	function automatic logic [7:0] perm_ipinv(input logic [7:0] v);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++)
			r[7-i] = v[8-int'(IPINV_TAB[i])];
		return r;
	endfunction

	// Expansion of the right half to eight bits
	function automatic logic [7:0] perm_ep(input logic [3:0] v);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++)
			r[7-i] = v[4-int'(EP_TAB[i])];
		return r;
	endfunction

	function automatic logic [3:0] perm_p4(input logic [3:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 4; i++)
			r[3-i] = v[4-int'(P4_TAB[i])];
		return r;
	endfunction

	// Row from outer bits, column from inner bits
	function automatic sbox_val_t sbox0(input logic [3:0] nib);
		return S0_TAB[{nib[3], nib[0]}][nib[2:1]];
	endfunction

	function automatic sbox_val_t sbox1(input logic [3:0] nib);
		return S1_TAB[{nib[3], nib[0]}][nib[2:1]];
	endfunction

	// One Feistel round: left half takes the mixed right half, right passes
	function automatic logic [7:0] round_fn(input logic [7:0] x, input logic [7:0] k);
		logic [7:0] e;
		logic [3:0] s;
		logic [3:0] p;
		e = perm_ep(x[3:0]) ^ k;
		s = {sbox0(e[7:4]), sbox1(e[3:0])};
		p = perm_p4(s);
		return {x[7:4] ^ p, x[3:0]};
	endfunction

endpackage

// ----- rtl/sdes_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES stream interfaces
// Valid/ready channels for byte requests and result bytes.
// ----------------------------------------------------------------------------

// Request channel: operation and byte
interface sdes_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_in;

	modport source (output valid, output cmd, output data_in, input ready);
	modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

// Result channel: processed byte
interface sdes_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

// ----- rtl/sdes_key_sched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES key schedule
// Holds the 10-bit key and derives subkeys K1 and K2 from it with fixed wiring.
// ----------------------------------------------------------------------------
module sdes_key_sched
	import sdes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_we,
	input  logic [KEY_W-1:0] key_wdata,
	output sdes_subkeys_t    subkeys
);

	logic [KEY_W-1:0] key_q;
	logic [9:0]       p10;
	logic [4:0]       hl;
	logic [4:0]       hr;

	// Key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_we) begin
			key_q <= key_wdata;
		end
	end

	// P10, halves rotated left by 1 for K1 and by 3 in total for K2
	always_comb begin
		p10 = perm_p10(key_q);
		hl  = p10[9:5];
		hr  = p10[4:0];
		subkeys.k1 = perm_p8({hl[3:0], hl[4], hr[3:0], hr[4]});
		subkeys.k2 = perm_p8({hl[1:0], hl[4:2], hr[1:0], hr[4:2]});
	end

endmodule

// ----- rtl/sdes_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES datapath
// Input register, both rounds in one pass of logic, and a result register.
// ----------------------------------------------------------------------------
module sdes_datapath
	import sdes_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  sdes_subkeys_t subkeys,
	sdes_req_if.sink      req,
	sdes_rsp_if.source    rsp
);

	logic              valid_s1;
	logic              cmd_s1;
	logic [DATA_W-1:0] data_s1;
	logic              valid_s2;
	logic [DATA_W-1:0] data_s2;
	logic              en_s1;
	logic              en_s2;
	logic [7:0]        ka;
	logic [7:0]        kb;
	logic [7:0]        x_ip;
	logic [7:0]        x_r1;
	logic [7:0]        x_r2;
	logic [DATA_W-1:0] result;

	// Stage enables: a stage loads when it is empty or its downstream has room
	assign en_s2     = !valid_s2 || rsp.ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign req.ready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= req.valid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			cmd_s1  <= req.cmd;
			data_s1 <= req.data_in;
		end
	end

	// Cipher: IP, round, half swap, round, IP inverse
	always_comb begin
		if (cmd_s1 == CMD_DECRYPT) begin
			ka = subkeys.k2;
			kb = subkeys.k1;
		end else begin
			ka = subkeys.k1;
			kb = subkeys.k2;
		end
		x_ip   = perm_ip(data_s1);
		x_r1   = round_fn(x_ip, ka);
		x_r2   = round_fn({x_r1[3:0], x_r1[7:4]}, kb);
		result = perm_ipinv(x_r2);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1)
			data_s2 <= result;
	end

	assign rsp.valid    = valid_s2;
	assign rsp.data_out = data_s2;

endmodule

// ----- rtl/sdes_byte_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES byte cipher
// Simplified DES encryption and decryption of one byte per request.
// ----------------------------------------------------------------------------
// A request carries cmd (0 encrypts, 1 decrypts) and a byte; each request
// yields one result byte, in order. The block accepts one request per clock
// unless the result channel stalls. An accepted byte goes into the input
// register, then IP, both rounds and IP inverse in one pass of logic into the
// result register. Backpressure on the result channel stalls the two-stage
// pipeline. The 10-bit key is written through cipher_key_we/cipher_key
// (first key bit in the MSB, reset 0); subkeys follow it through fixed wiring,
// so write it only while no request is in flight.
module sdes_byte_cipher
	import sdes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cipher_key_we,
	input  logic [KEY_W-1:0] cipher_key,
	sdes_req_if.sink         item,
	sdes_rsp_if.source       result
);

	sdes_subkeys_t subkeys;

	// Key register and subkey derivation
	sdes_key_sched u_key_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_we    (cipher_key_we),
		.key_wdata (cipher_key),
		.subkeys   (subkeys)
	);

	// Byte pipeline
	sdes_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.subkeys (subkeys),
		.req     (item),
		.rsp     (result)
	);

endmodule
